FILE: src/byte_signature_region_scanner_macros.svh
// Assertion macros for the byte signature region scanner checker
`ifndef BYTE_SIGNATURE_REGION_SCANNER_MACROS_SVH
`define BYTE_SIGNATURE_REGION_SCANNER_MACROS_SVH

// check a property while out of reset
`define BSRS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bsrs assertion failed");

// check a property on every clock edge, reset included
`define BSRS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bsrs assertion failed");

`endif

FILE: src/bsrs_pkg.sv
// Shared types, tag constants and result codes for the byte signature region scanner
package bsrs_pkg;

  localparam int TAG_LEN          = 10;
  localparam int ID_INDEX         = 2;
  localparam int OFFSET_BITS_DEF  = 16;
  localparam int LIMIT_W          = 16;
  localparam int POS_W            = 16;
  localparam logic [LIMIT_W-1:0] SCAN_LIMIT_RST = 16'd4096;

  localparam logic [7:0] TAG_START [TAG_LEN] =
    '{8'h57, 8'h6A, 8'h00, 8'hBF, 8'hDE, 8'hC0, 8'hED, 8'hFE, 8'h5F, 8'h5F};
  localparam logic [7:0] TAG_END [TAG_LEN] =
    '{8'h56, 8'h6A, 8'h45, 8'hBE, 8'hDE, 8'hC0, 8'hAD, 8'hDE, 8'h5E, 8'h5E};
  localparam logic [7:0] TAG_STOP [TAG_LEN] =
    '{8'h52, 8'h6A, 8'h45, 8'hBA, 8'h5E, 8'hEA, 8'h15, 8'h0D, 8'h5A, 8'h5A};

  typedef enum logic [1:0] {
    STATUS_REGION = 2'd0,
    STATUS_STOP   = 2'd1,
    STATUS_LIMIT  = 2'd2
  } status_t;

  typedef struct packed {
    logic hit_start;
    logic hit_end;
    logic hit_stop;
  } match_t;

  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [7:0]       region_id;
    logic [POS_W-1:0] region_start;
    logic [POS_W-1:0] region_end;
  } result_t;

endpackage

FILE: src/bsrs_match.sv
// Window compare against the start, end and stop tags
module bsrs_match (
  input  logic [7:0]       win_i [bsrs_pkg::TAG_LEN],
  output bsrs_pkg::match_t match_o
);
  import bsrs_pkg::*;

  logic [TAG_LEN-1:0] eq_start;
  logic [TAG_LEN-1:0] eq_end;
  logic [TAG_LEN-1:0] eq_stop;

  always_comb begin
    for (int i = 0; i < TAG_LEN; i++) begin
      eq_start[i] = (i == ID_INDEX) ? 1'b1 : (win_i[i] == TAG_START[i]);
      eq_end[i]   = (win_i[i] == TAG_END[i]);
      eq_stop[i]  = (win_i[i] == TAG_STOP[i]);
    end
  end

  assign match_o.hit_start = &eq_start;
  assign match_o.hit_end   = &eq_end;
  assign match_o.hit_stop  = &eq_stop;

endmodule

FILE: src/bsrs_core.sv
// Scan state, offset and limit tracking, and result forming for one byte
module bsrs_core #(
  parameter int OFFSET_BITS = bsrs_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance_i,
  input  logic [7:0]                   byte_i,
  input  logic                         begin_i,
  input  logic [bsrs_pkg::LIMIT_W-1:0] scan_limit_i,
  output bsrs_pkg::result_t            result_o
);
  import bsrs_pkg::*;

  localparam int CW = (OFFSET_BITS > LIMIT_W) ? OFFSET_BITS : LIMIT_W;
  localparam logic [CW-1:0] LIM_CAP = CW'({OFFSET_BITS{1'b1}}) - CW'(1);

  logic [7:0]             win_r [TAG_LEN];
  logic [7:0]             win_nxt [TAG_LEN];
  logic [7:0]             win_c [TAG_LEN];
  logic [7:0]             win_sh [TAG_LEN];
  logic [OFFSET_BITS-1:0] off_r, off_nxt, off_c;
  logic                   pend_r, pend_nxt, pend_c;
  logic [OFFSET_BITS-1:0] pend_off_r, pend_off_nxt, pend_off_c;
  logic [7:0]             id_r, id_nxt, id_c;
  logic                   fin_r, fin_nxt, fin_c;
  logic [CW-1:0]          off_ext, lim_raw, lim_eff;
  match_t                 match;

  always_comb begin
    if (begin_i) begin
      for (int i = 0; i < TAG_LEN; i++) win_c[i] = 8'h00;
      off_c      = '0;
      pend_c     = 1'b0;
      pend_off_c = '0;
      id_c       = 8'h00;
      fin_c      = 1'b0;
    end else begin
      win_c      = win_r;
      off_c      = off_r;
      pend_c     = pend_r;
      pend_off_c = pend_off_r;
      id_c       = id_r;
      fin_c      = fin_r;
    end
  end

  always_comb begin
    for (int i = 0; i < TAG_LEN - 1; i++) win_sh[i] = win_c[i+1];
    win_sh[TAG_LEN-1] = byte_i;
  end

  bsrs_match u_match (
    .win_i   (win_sh),
    .match_o (match)
  );

  assign off_ext = CW'(off_c);
  assign lim_raw = CW'(scan_limit_i);
  assign lim_eff = (lim_raw > LIM_CAP) ? LIM_CAP : lim_raw;

  always_comb begin
    win_nxt      = win_c;
    off_nxt      = off_c;
    pend_nxt     = pend_c;
    pend_off_nxt = pend_off_c;
    id_nxt       = id_c;
    fin_nxt      = fin_c;
    result_o     = '0;
    result_o.status = STATUS_REGION;
    if (!fin_c) begin
      if (off_ext > lim_eff) begin
        fin_nxt         = 1'b1;
        result_o.valid  = 1'b1;
        result_o.status = STATUS_LIMIT;
      end else begin
        win_nxt = win_sh;
        off_nxt = off_c + OFFSET_BITS'(1);
        if (match.hit_start) begin
          id_nxt       = win_sh[ID_INDEX];
          pend_nxt     = 1'b1;
          pend_off_nxt = off_c + OFFSET_BITS'(1);
        end else if (match.hit_end) begin
          if (pend_c) begin
            pend_nxt              = 1'b0;
            result_o.valid        = 1'b1;
            result_o.status       = STATUS_REGION;
            result_o.region_id    = id_c;
            result_o.region_start = POS_W'(pend_off_c);
            result_o.region_end   = POS_W'(off_c - OFFSET_BITS'(TAG_LEN - 1));
          end
        end else if (match.hit_stop) begin
          fin_nxt         = 1'b1;
          result_o.valid  = 1'b1;
          result_o.status = STATUS_STOP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAG_LEN; i++) win_r[i] <= 8'h00;
      off_r      <= '0;
      pend_r     <= 1'b0;
      pend_off_r <= '0;
      id_r       <= 8'h00;
      fin_r      <= 1'b0;
    end else if (advance_i) begin
      win_r      <= win_nxt;
      off_r      <= off_nxt;
      pend_r     <= pend_nxt;
      pend_off_r <= pend_off_nxt;
      id_r       <= id_nxt;
      fin_r      <= fin_nxt;
    end
  end

endmodule

FILE: src/byte_signature_region_scanner.sv
// Top level of the byte signature region scanner: input register, result register, config
//
//  channel | ports                         | payload
//  --------+-------------------------------+---------------------------------------------
//  in      | in_tvalid/in_tready           | tdata: data_byte; tuser: scan_begin
//  out     | out_tvalid/out_tready         | tdata: region_id, start, end; tuser: status
//  cfg     | cfg_we                        | cfg_wdata: scan_limit
//
//  One byte per cycle while the result register is free or being read; an accepted request
//  moves from the input register into the result register under that same condition.
//  The window compare and offset update sit between the input and result registers.
//  Reset clears the scan state and sets scan_limit to 4096.
//  A stalled result holds; a new request is taken while the input register is empty or moving.
module byte_signature_region_scanner #(
  parameter int OFFSET_BITS = bsrs_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] data_byte
  input  logic [0:0]                   in_tuser,   // [0] scan_begin
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [39:0]                  out_tdata,  // [7:0] region_id, [23:8] region_start,
                                                   // [39:24] region_end
  output logic [1:0]                   out_tuser,  // [1:0] status
  input  logic                         cfg_we,
  input  logic [bsrs_pkg::LIMIT_W-1:0] cfg_wdata
);
  import bsrs_pkg::*;

  logic               in_valid_r;
  logic [7:0]         in_byte_r;
  logic               in_begin_r;
  logic [LIMIT_W-1:0] scan_limit_r;
  logic               advance;
  result_t            result;
  result_t            res_r;

  assign advance   = in_valid_r && (!res_r.valid || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_limit_r <= SCAN_LIMIT_RST;
    end else if (cfg_we) begin
      scan_limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata;
      in_begin_r <= in_tuser[0];
    end
  end

  bsrs_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance_i    (advance),
    .byte_i       (in_byte_r),
    .begin_i      (in_begin_r),
    .scan_limit_i (scan_limit_r),
    .result_o     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else if (advance) begin
      res_r <= result;
    end else if (out_tready) begin
      res_r.valid <= 1'b0;
    end
  end

  assign out_tvalid = res_r.valid;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {res_r.region_end, res_r.region_start, res_r.region_id};

endmodule

FILE: src/bsrs_checker.sv
// Port-level checker for the byte signature region scanner and its bind
`include "byte_signature_region_scanner_macros.svh"

module bsrs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import bsrs_pkg::*;

  logic        out_stall;
  logic [41:0] out_word;
  logic        status_known;
  logic        status_end;

  assign out_stall    = out_tvalid && !out_tready;
  assign out_word     = {out_tuser, out_tdata};
  assign status_known = out_tuser inside {STATUS_REGION, STATUS_STOP, STATUS_LIMIT};
  assign status_end   = out_tuser inside {STATUS_STOP, STATUS_LIMIT};

  `BSRS_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_tvalid && $stable(out_word))
  `BSRS_ASSERT(a_status_code, clk, rst_n, out_tvalid |-> status_known)
  `BSRS_ASSERT(a_status_zero_data, clk, rst_n, out_tvalid && status_end |-> out_tdata == '0)
  `BSRS_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_tvalid)

endmodule

bind byte_signature_region_scanner bsrs_checker u_bsrs_checker (.*);
